### sv/dfhe_pkg.sv
// Package with the token and result types and the fixed-code table for the deflate encoder.
`default_nettype none

package dfhe_pkg;

    // Token command codes.
    localparam logic [1:0] CMD_LITERAL  = 2'd0;
    localparam logic [1:0] CMD_MATCH    = 2'd1;
    localparam logic [1:0] CMD_END      = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    // Symbol numbers and fixed-code bases from the deflate format.
    localparam logic [8:0] EOB_SYMBOL      = 9'd256;
    localparam logic [8:0] LEN_MAX_SYMBOL  = 9'd285;
    localparam logic [8:0] LIT_LOW_LAST    = 9'd143;
    localparam logic [8:0] LIT_LAST        = 9'd255;
    localparam logic [8:0] LEN_SHORT_LAST  = 9'd279;
    localparam logic [8:0] LEN_LONG_FIRST  = 9'd280;
    localparam logic [8:0] CODE_BASE_LOW   = 9'h030;
    localparam logic [8:0] CODE_BASE_HIGH  = 9'h190;
    localparam logic [8:0] CODE_BASE_LONG  = 9'h0C0;
    localparam logic [8:0] LIT_HIGH_FIRST  = 9'd144;
    localparam logic [7:0] LEN_M3_MAX      = 8'd255;
    localparam logic [15:0] MAX_DISTANCE   = 16'd32768;

    // One input token.
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  literal_byte;
        logic [7:0]  length_minus_three;
        logic [15:0] match_distance;
    } dfhe_token_t;

    // One encoded result.
    typedef struct packed {
        logic [8:0]  symbol_code;
        logic [3:0]  symbol_code_bits;
        logic [4:0]  length_extra_value;
        logic [2:0]  length_extra_bits;
        logic        has_distance;
        logic [4:0]  distance_code;
        logic [12:0] distance_extra_value;
        logic [3:0]  distance_extra_bits;
    } dfhe_result_t;

    // Literal/length half of a result.
    typedef struct packed {
        logic [8:0] symbol_code;
        logic [3:0] symbol_code_bits;
        logic [4:0] length_extra_value;
        logic [2:0] length_extra_bits;
    } dfhe_lit_len_t;

    // Distance half of a result.
    typedef struct packed {
        logic [4:0]  distance_code;
        logic [12:0] distance_extra_value;
        logic [3:0]  distance_extra_bits;
    } dfhe_dist_t;

    // Fixed Huffman code of one literal/length symbol.
    typedef struct packed {
        logic [8:0] code;
        logic [3:0] bits;
    } dfhe_fixed_code_t;

    // Map a literal/length symbol to its fixed code and code length.
    function automatic dfhe_fixed_code_t fixed_code(input logic [8:0] sym);
        dfhe_fixed_code_t fc;
        if (sym <= LIT_LOW_LAST)
        begin
            fc.code = CODE_BASE_LOW + sym;
            fc.bits = 4'd8;
        end
        else if (sym <= LIT_LAST)
        begin
            fc.code = CODE_BASE_HIGH + (sym - LIT_HIGH_FIRST);
            fc.bits = 4'd9;
        end
        else if (sym <= LEN_SHORT_LAST)
        begin
            fc.code = sym - EOB_SYMBOL;
            fc.bits = 4'd7;
        end
        else
        begin
            fc.code = CODE_BASE_LONG + (sym - LEN_LONG_FIRST);
            fc.bits = 4'd8;
        end
        return fc;
    endfunction

endpackage

`default_nettype wire

### sv/deflate_fixed_huffman_token_encoder.sv
// Top level of the deflate fixed-Huffman token encoder.
//
//   Channel   Ports                 Transfer
//   -------   -------------------   ------------------------------------
//   token     start, busy, token    start high and busy low at a clock edge
//   result    strobe, result        strobe high for one cycle, always taken
//
// A token is captured in the input register; the symbol lookups run
// combinationally between the input register and the result register, which
// holds the result and drives its strobe. busy is always low: a token can be
// taken every cycle. A token with the reserved command gives no result.
// Reset clears the valid flags only. The receiver cannot stall.
`default_nettype none

module deflate_fixed_huffman_token_encoder
    import dfhe_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire dfhe_token_t  token,
    output logic              strobe,
    output dfhe_result_t      result
);

    logic          tok_valid_reg;
    logic          tok_valid_next;
    dfhe_token_t   tok_reg;
    logic          res_valid_reg;
    logic          res_valid_next;
    dfhe_result_t  res_reg;
    dfhe_result_t  res_next;
    dfhe_lit_len_t lit_len;
    dfhe_dist_t    dist_fields;
    logic          is_match;

    assign busy = 1'b0;

    // Input register.
    assign tok_valid_next = start && !busy && (token.command != CMD_RESERVED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            tok_reg <= token;
        end
    end

    // Symbol lookups.
    dfhe_len_enc u_len_enc
    (
        .token   (tok_reg),
        .lit_len (lit_len)
    );

    dfhe_dist_enc u_dist_enc
    (
        .match_distance (tok_reg.match_distance),
        .dist_fields    (dist_fields)
    );

    // Assemble the result; distance fields are zero unless the token is a match.
    assign is_match = (tok_reg.command == CMD_MATCH);

    always_comb
    begin
        res_next.symbol_code          = lit_len.symbol_code;
        res_next.symbol_code_bits     = lit_len.symbol_code_bits;
        res_next.length_extra_value   = lit_len.length_extra_value;
        res_next.length_extra_bits    = lit_len.length_extra_bits;
        res_next.has_distance         = is_match;
        res_next.distance_code        = is_match ? dist_fields.distance_code : '0;
        res_next.distance_extra_value = is_match ? dist_fields.distance_extra_value : '0;
        res_next.distance_extra_bits  = is_match ? dist_fields.distance_extra_bits : '0;
    end

    assign res_valid_next = tok_valid_reg;

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign strobe = res_valid_reg;
    assign result = res_reg;

    // Every result comes from an earlier transfer of a non-reserved token.
    a_strobe_from_token: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ($past(start && !busy, 2) && ($past(token.command, 2) != CMD_RESERVED)))
        else $error("result strobe without a matching token transfer");

    // A valid token always produces a result.
    a_token_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (token.command != CMD_RESERVED)) |-> ##2 strobe)
        else $error("token transfer lost");

    // Length symbols use 7- or 8-bit codes only.
    a_match_code_len: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.has_distance) |-> (result.symbol_code_bits != 4'd9))
        else $error("match result with a 9-bit symbol code");

    // Literals and end of block carry no extra bits.
    a_no_extra_without_match: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.has_distance) |->
            ((result.length_extra_bits == '0) && (result.distance_extra_bits == '0)))
        else $error("extra bits on a non-match result");

endmodule

`default_nettype wire

### sv/dfhe_len_enc.sv
// Literal, length and end-of-block symbol lookup with length extra bits.
`default_nettype none

module dfhe_len_enc
    import dfhe_pkg::*;
(
    input  wire dfhe_token_t   token,
    output dfhe_lit_len_t      lit_len
);

    logic [2:0]       top_bit;
    logic [2:0]       extra_cnt;
    logic [1:0]       sub_sel;
    logic [7:0]       low_mask;
    logic [8:0]       sym;
    dfhe_fixed_code_t fc;

    // Position of the highest set bit of the length offset (meaningful when it is 8 or more).
    always_comb
    begin
        top_bit = 3'd3;
        for (int i = 3; i < 8; i++)
        begin
            if (token.length_minus_three[i])
            begin
                top_bit = 3'(i);
            end
        end
    end

    // Length range table: four symbols per power of two.
    assign extra_cnt  = top_bit - 3'd2;
    assign sub_sel    = 2'(token.length_minus_three >> extra_cnt);
    assign low_mask   = (8'd1 << extra_cnt) - 8'd1;

    // Symbol selection and extra bits.
    always_comb
    begin
        lit_len.length_extra_value = '0;
        lit_len.length_extra_bits  = '0;
        case (token.command)
            CMD_LITERAL:
            begin
                sym = {1'b0, token.literal_byte};
            end
            CMD_MATCH:
            begin
                if (token.length_minus_three == LEN_M3_MAX)
                begin
                    sym = LEN_MAX_SYMBOL;
                end
                else if (token.length_minus_three[7:3] == '0)
                begin
                    sym = EOB_SYMBOL + 9'd1 + {1'b0, token.length_minus_three};
                end
                else
                begin
                    sym = 9'd253 + {4'd0, top_bit, 2'b00} + {7'd0, sub_sel};
                    lit_len.length_extra_value =
                        5'(token.length_minus_three & low_mask);
                    lit_len.length_extra_bits  = extra_cnt;
                end
            end
            default:
            begin
                sym = EOB_SYMBOL;
            end
        endcase
    end

    // Fixed code of the chosen symbol.
    assign fc                       = fixed_code(sym);
    assign lit_len.symbol_code      = fc.code;
    assign lit_len.symbol_code_bits = fc.bits;

endmodule

`default_nettype wire

### sv/dfhe_dist_enc.sv
// Distance symbol lookup with distance extra bits.
`default_nettype none

module dfhe_dist_enc
    import dfhe_pkg::*;
(
    input  wire logic [15:0] match_distance,
    output dfhe_dist_t       dist_fields
);

    logic [15:0] dist_sat;
    logic [14:0] d;
    logic [3:0]  top_bit;
    logic [3:0]  extra_cnt;
    logic [14:0] low_mask;

    // Saturate the distance into 1..32768 and take it minus one.
    always_comb
    begin
        if (match_distance == '0)
        begin
            dist_sat = 16'd1;
        end
        else if (match_distance > MAX_DISTANCE)
        begin
            dist_sat = MAX_DISTANCE;
        end
        else
        begin
            dist_sat = match_distance;
        end
    end

    assign d = 15'(dist_sat - 16'd1);

    // Highest set bit of the offset.
    always_comb
    begin
        top_bit = 4'd2;
        for (int i = 2; i < 15; i++)
        begin
            if (d[i])
            begin
                top_bit = 4'(i);
            end
        end
    end

    assign extra_cnt = top_bit - 4'd1;
    assign low_mask  = (15'd1 << extra_cnt) - 15'd1;

    // Two symbols per power of two; the first four distances have no extra bits.
    always_comb
    begin
        if (d[14:2] == '0)
        begin
            dist_fields.distance_code        = {3'd0, d[1:0]};
            dist_fields.distance_extra_value = '0;
            dist_fields.distance_extra_bits  = '0;
        end
        else
        begin
            dist_fields.distance_code        = {top_bit, d[extra_cnt]};
            dist_fields.distance_extra_value = 13'(d & low_mask);
            dist_fields.distance_extra_bits  = extra_cnt;
        end
    end

endmodule

`default_nettype wire

### test/deflate_fixed_huffman_token_encoder_tb.sv
// Self-checking testbench for the deflate fixed-Huffman token encoder.
`timescale 1ns / 100ps

module deflate_fixed_huffman_token_encoder_tb;
    import dfhe_pkg::*;

    localparam int TOKEN_COUNT  = 900;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    dfhe_token_t  token = '0;
    logic         strobe;
    dfhe_result_t result;

    // Tokens waiting to be driven and encodings waiting to come out.
    dfhe_token_t  pending_tokens[$];
    dfhe_result_t expected_codes[$];

    logic token_taken = 1'b0;
    int   gap_left = 0;
    int   tokens_sent = 0;
    int   error_count = 0;
    int   cycle_count = 0;

    deflate_fixed_huffman_token_encoder i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .token  (token),
        .strobe (strobe),
        .result (result)
    );

    // Free-running clock with a 10 ns period.
    always #5 clk = ~clk;

    // Index of the highest set bit.
    function automatic int unsigned msb_index(input int unsigned v);
        int unsigned n;
        n = 0;
        while (v > 1)
        begin
            v = v >> 1;
            n++;
        end
        return n;
    endfunction

    // Work out the fixed-Huffman encoding of one token.
    function automatic dfhe_result_t encode_token(input dfhe_token_t t);
        dfhe_result_t r;
        int unsigned  sym;
        int unsigned  lm3;
        int unsigned  d;
        int unsigned  n;
        r = '0;
        lm3 = t.length_minus_three;
        case (t.command)
            CMD_LITERAL: sym = t.literal_byte;
            CMD_END:     sym = EOB_SYMBOL;
            default:
            begin
                // Length symbol: four symbols per power of two above the first eight.
                if (lm3 == LEN_M3_MAX)
                    sym = LEN_MAX_SYMBOL;
                else if (lm3 < 8)
                    sym = 257 + lm3;
                else
                begin
                    n = msb_index(lm3);
                    sym = 257 + 4 * (n - 1) + ((lm3 >> (n - 2)) & 3);
                    r.length_extra_value = 5'(lm3 & ((1 << (n - 2)) - 1));
                    r.length_extra_bits = 3'(n - 2);
                end
                // Distance symbol, with the distance clamped to 1..32768.
                d = t.match_distance;
                if (d == 0)
                    d = 1;
                if (d > MAX_DISTANCE)
                    d = MAX_DISTANCE;
                d = d - 1;
                r.has_distance = 1'b1;
                if (d < 4)
                    r.distance_code = 5'(d);
                else
                begin
                    n = msb_index(d);
                    r.distance_code = 5'(2 * n + ((d >> (n - 1)) & 1));
                    r.distance_extra_value = 13'(d & ((1 << (n - 1)) - 1));
                    r.distance_extra_bits = 4'(n - 1);
                end
            end
        endcase
        // Fixed code ranges of the literal/length alphabet.
        if (sym < LIT_HIGH_FIRST)
        begin
            r.symbol_code = 9'(CODE_BASE_LOW + sym);
            r.symbol_code_bits = 4'd8;
        end
        else if (sym < EOB_SYMBOL)
        begin
            r.symbol_code = 9'(CODE_BASE_HIGH + sym - LIT_HIGH_FIRST);
            r.symbol_code_bits = 4'd9;
        end
        else if (sym < LEN_LONG_FIRST)
        begin
            r.symbol_code = 9'(sym - EOB_SYMBOL);
            r.symbol_code_bits = 4'd7;
        end
        else
        begin
            r.symbol_code = 9'(CODE_BASE_LONG + sym - LEN_LONG_FIRST);
            r.symbol_code_bits = 4'd8;
        end
        return r;
    endfunction

    // Token with the given command and random values in all other fields.
    function automatic dfhe_token_t make_token(input logic [1:0] cmd);
        dfhe_token_t t;
        t.command = cmd;
        t.literal_byte = 8'($urandom);
        t.length_minus_three = 8'($urandom);
        t.match_distance = 16'($urandom);
        return t;
    endfunction

    function automatic dfhe_token_t make_match(input int lm3, input int distance);
        dfhe_token_t t;
        t = make_token(CMD_MATCH);
        t.length_minus_three = 8'(lm3);
        t.match_distance = 16'(distance);
        return t;
    endfunction

    function automatic dfhe_token_t make_literal(input int value);
        dfhe_token_t t;
        t = make_token(CMD_LITERAL);
        t.literal_byte = 8'(value);
        return t;
    endfunction

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            error_count++;
        end
    endtask

    // Driver: presents the next token once the previous transfer is done.
    always @(negedge clk)
    begin
        if (rst_n && (!start || token_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_tokens.size() > 0)
            begin
                token <= pending_tokens.pop_front();
                start <= 1'b1;
                tokens_sent++;
                // Every third stretch of 64 tokens runs back to back.
                if ((tokens_sent / 64) % 3 == 0)
                    gap_left = 0;
                else
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: gap_left = 0;
                        6, 7, 8:          gap_left = $urandom_range(1, 3);
                        default:          gap_left = $urandom_range(8, 30);
                    endcase
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: records accepted tokens and checks each result strobe.
    always @(posedge clk)
    begin
        dfhe_result_t exp_code;
        token_taken <= start && !busy;
        if (rst_n)
        begin
            if (start && !busy && token.command != CMD_RESERVED)
                expected_codes.push_back(encode_token(token));
            if (strobe)
            begin
                if (expected_codes.size() == 0)
                begin
                    $error("result strobe with no token outstanding");
                    error_count++;
                end
                else
                begin
                    exp_code = expected_codes.pop_front();
                    check_field("symbol_code", exp_code.symbol_code, result.symbol_code);
                    check_field("symbol_code_bits", exp_code.symbol_code_bits,
                                result.symbol_code_bits);
                    check_field("length_extra_value", exp_code.length_extra_value,
                                result.length_extra_value);
                    check_field("length_extra_bits", exp_code.length_extra_bits,
                                result.length_extra_bits);
                    check_field("has_distance", exp_code.has_distance, result.has_distance);
                    check_field("distance_code", exp_code.distance_code, result.distance_code);
                    check_field("distance_extra_value", exp_code.distance_extra_value,
                                result.distance_extra_value);
                    check_field("distance_extra_bits", exp_code.distance_extra_bits,
                                result.distance_extra_bits);
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("deflate_fixed_huffman_token_encoder test failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int          lm3_edges[8];
        int          made;
        int          pick;
        int          n;
        dfhe_token_t t;

        // Literal range edges and end of block.
        pending_tokens.push_back(make_literal(0));
        pending_tokens.push_back(make_literal(143));
        pending_tokens.push_back(make_literal(144));
        pending_tokens.push_back(make_literal(255));
        pending_tokens.push_back(make_token(CMD_END));
        // Length edges: no extra bits, each extra-bit count, and length 258.
        lm3_edges = '{0, 7, 8, 16, 32, 64, 128, 254};
        foreach (lm3_edges[i])
            pending_tokens.push_back(make_match(lm3_edges[i], 1 << (i * 2)));
        pending_tokens.push_back(make_match(255, 258));
        // Distance edges, including zero and values past 32768 that saturate.
        pending_tokens.push_back(make_match(3, 0));
        pending_tokens.push_back(make_match(4, 4));
        pending_tokens.push_back(make_match(5, 5));
        pending_tokens.push_back(make_match(6, 24577));
        pending_tokens.push_back(make_match(127, 32768));
        pending_tokens.push_back(make_match(128, 32769));
        pending_tokens.push_back(make_match(200, 65535));
        // Reserved command is dropped without a result.
        pending_tokens.push_back(make_token(CMD_RESERVED));
        pending_tokens.push_back(make_token(CMD_END));
        pending_tokens.push_back(make_token(CMD_RESERVED));
        pending_tokens.push_back(make_literal(8'hA5));

        // Random token stream; reserved tokens do not count.
        made = 0;
        while (made < TOKEN_COUNT)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 42)
                t = make_token(CMD_LITERAL);
            else if (pick < 87)
            begin
                t = make_token(CMD_MATCH);
                // Spread distances over every extra-bit count.
                case ($urandom_range(0, 3))
                    0:
                    begin
                        n = $urandom_range(0, 15);
                        t.match_distance = 16'((1 << n) + $urandom_range(0, (1 << n) - 1));
                    end
                    1: t.match_distance = 16'($urandom_range(1, 32));
                    2: t.match_distance = 16'($urandom_range(1, 32768));
                    default: ;
                endcase
            end
            else if (pick < 93)
                t = make_token(CMD_END);
            else
                t = make_token(CMD_RESERVED);
            if (t.command != CMD_RESERVED)
                made++;
            pending_tokens.push_back(t);
        end

        // Hold reset, then release it.
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Wait for all tokens to be taken and all results to arrive.
        while (pending_tokens.size() != 0 || start)
            @(negedge clk);
        while (expected_codes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("deflate_fixed_huffman_token_encoder test passed");
        else
            $display("deflate_fixed_huffman_token_encoder test failed");
        $finish;
    end

endmodule

### filelist.f
sv/dfhe_pkg.sv
sv/dfhe_len_enc.sv
sv/dfhe_dist_enc.sv
sv/deflate_fixed_huffman_token_encoder.sv
test/deflate_fixed_huffman_token_encoder_tb.sv
